// ===== rtl/ptd_pkg.sv =====
// Shared types, codes and width helpers for the point-to-triangle distance unit.
// No dependencies.
package ptd_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF   = 16;

   localparam logic [2:0] FEAT_VERTEX0  = 3'd0;
   localparam logic [2:0] FEAT_VERTEX1  = 3'd1;
   localparam logic [2:0] FEAT_VERTEX2  = 3'd2;
   localparam logic [2:0] FEAT_EDGE01   = 3'd3;
   localparam logic [2:0] FEAT_EDGE12   = 3'd4;
   localparam logic [2:0] FEAT_EDGE20   = 3'd5;
   localparam logic [2:0] FEAT_INTERIOR = 3'd6;

   typedef enum logic [2:0] {
      SRC_ZERO,
      SRC_ONE,
      SRC_QA,
      SRC_QB,
      SRC_ONE_MINUS_QA
   } src_type;

   typedef enum logic [1:0] {
      DIV_RUN,
      DIV_ZERO,
      DIV_ONE
   } div_mode_type;

   function automatic int dist_width(int cw, int fb);
      return 2 * (cw - fb) + 2 + fb;
   endfunction

endpackage

// ===== rtl/ptd_if.sv =====
// Valid/ready channel interfaces for query items and result items.
// Depends on ptd_pkg.
interface ptd_req_if #(
   parameter int COORD_WIDTH = ptd_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] query_x;
   logic signed [COORD_WIDTH-1:0] query_y;
   logic signed [COORD_WIDTH-1:0] query_z;
   logic signed [COORD_WIDTH-1:0] corner0_x;
   logic signed [COORD_WIDTH-1:0] corner0_y;
   logic signed [COORD_WIDTH-1:0] corner0_z;
   logic signed [COORD_WIDTH-1:0] corner1_x;
   logic signed [COORD_WIDTH-1:0] corner1_y;
   logic signed [COORD_WIDTH-1:0] corner1_z;
   logic signed [COORD_WIDTH-1:0] corner2_x;
   logic signed [COORD_WIDTH-1:0] corner2_y;
   logic signed [COORD_WIDTH-1:0] corner2_z;

   modport source (
      output valid, query_x, query_y, query_z, corner0_x, corner0_y, corner0_z,
             corner1_x, corner1_y, corner1_z, corner2_x, corner2_y, corner2_z,
      input  ready
   );
   modport sink (
      input  valid, query_x, query_y, query_z, corner0_x, corner0_y, corner0_z,
             corner1_x, corner1_y, corner1_z, corner2_x, corner2_y, corner2_z,
      output ready
   );
endinterface

interface ptd_rsp_if #(
   parameter int COORD_WIDTH = ptd_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = ptd_pkg::FRAC_BITS_DEF
);
   localparam int DW = ptd_pkg::dist_width(COORD_WIDTH, FRAC_BITS);
   logic                          valid;
   logic                          ready;
   logic [DW-1:0]                 dist_squared;
   logic signed [COORD_WIDTH-1:0] nearest_x;
   logic signed [COORD_WIDTH-1:0] nearest_y;
   logic signed [COORD_WIDTH-1:0] nearest_z;
   logic [2:0]                    feature;
   logic                          degenerate;

   modport source (
      output valid, dist_squared, nearest_x, nearest_y, nearest_z, feature, degenerate,
      input  ready
   );
   modport sink (
      input  valid, dist_squared, nearest_x, nearest_y, nearest_z, feature, degenerate,
      output ready
   );
endinterface

// ===== rtl/ptd_delay.sv =====
// Enabled shift line that carries side data alongside the arithmetic stages.
// No dependencies.
module ptd_delay #(
   parameter int WD    = 1,
   parameter int DEPTH = 1
) (
   input  logic          clock,
   input  logic          en,
   input  logic [WD-1:0] din,
   output logic [WD-1:0] dout
);
   logic [WD-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];
endmodule

// ===== rtl/ptd_mul.sv =====
// Two-stage signed multiplier: four half-width partial products, then their sum.
// No dependencies.
module ptd_mul #(
   parameter int AW = 25,
   parameter int BW = 25
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [AW-1:0]    a,
   input  logic signed [BW-1:0]    b,
   output logic signed [AW+BW-1:0] p
);
   localparam int LA  = AW / 2;
   localparam int HA  = AW - LA;
   localparam int LB  = BW / 2;
   localparam int HB  = BW - LB;
   localparam int PWD = AW + BW;

   logic signed [LA:0]         a_lo;
   logic signed [HA-1:0]       a_hi;
   logic signed [LB:0]         b_lo;
   logic signed [HB-1:0]       b_hi;
   logic signed [HA+HB-1:0]    hh_ff;
   logic signed [HA+LB:0]      hl_ff;
   logic signed [LA+HB:0]      lh_ff;
   logic signed [LA+LB+1:0]    ll_ff;
   logic signed [PWD-1:0]      p_in;
   logic signed [PWD-1:0]      p_ff;

   assign a_lo = $signed({1'b0, a[LA-1:0]});
   assign a_hi = a[AW-1:LA];
   assign b_lo = $signed({1'b0, b[LB-1:0]});
   assign b_hi = b[BW-1:LB];

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff <= a_hi * b_hi;
         hl_ff <= a_hi * b_lo;
         lh_ff <= a_lo * b_hi;
         ll_ff <= a_lo * b_lo;
      end
   end

   assign p_in = (PWD'(hh_ff) <<< (LA + LB)) + (PWD'(hl_ff) <<< LA)
               + (PWD'(lh_ff) <<< LB) + PWD'(ll_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;
endmodule

// ===== rtl/ptd_div.sv =====
// Pipelined restoring divider giving num/den in [0,1] as unsigned fixed point.
// Depends on ptd_pkg.
module ptd_div #(
   parameter int NW = 106,
   parameter int QB = 28
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [NW-1:0] num,
   input  logic signed [NW-1:0] den,
   output logic [QB:0]          quo,
   output logic                 deg
);
   import ptd_pkg::*;

   localparam int RW = NW - 1;

   div_mode_type mode_ff [QB+1];
   logic         deg_ff  [QB+1];
   logic [RW-1:0] rem_ff [QB+1];
   logic [RW-1:0] dv_ff  [QB+1];
   logic [QB-1:0] q_ff   [QB+1];
   div_mode_type mode_in;
   logic         deg_in;

   always_comb begin
      mode_in = DIV_RUN;
      deg_in  = 1'b0;
      if (den <= 0) begin
         mode_in = DIV_ZERO;
         deg_in  = 1'b1;
      end else if (num <= 0) begin
         mode_in = DIV_ZERO;
      end else if (num >= den) begin
         mode_in = DIV_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode_ff[0] <= mode_in;
         deg_ff[0]  <= deg_in;
         rem_ff[0]  <= num[RW-1:0];
         dv_ff[0]   <= den[RW-1:0];
         q_ff[0]    <= '0;
      end
   end

   for (genvar i = 1; i <= QB; i++) begin : g_step
      logic [RW:0] r2;
      logic [RW:0] r2_sub;
      logic        ge;

      assign r2     = {rem_ff[i-1], 1'b0};
      assign r2_sub = r2 - {1'b0, dv_ff[i-1]};
      assign ge     = r2 >= {1'b0, dv_ff[i-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            mode_ff[i] <= mode_ff[i-1];
            deg_ff[i]  <= deg_ff[i-1];
            dv_ff[i]   <= dv_ff[i-1];
            rem_ff[i]  <= ge ? r2_sub[RW-1:0] : r2[RW-1:0];
            q_ff[i]    <= {q_ff[i-1][QB-2:0], ge};
         end
      end
   end

   always_comb begin
      case (mode_ff[QB])
         DIV_ONE:  quo = {1'b1, {QB{1'b0}}};
         DIV_ZERO: quo = '0;
         default:  quo = {1'b0, q_ff[QB]};
      endcase
   end

   assign deg = deg_ff[QB];
endmodule

// ===== rtl/point_triangle_distance_unit.sv =====
// Point-to-triangle squared distance, nearest point and feature, fully pipelined.
// Depends on ptd_pkg, ptd_if, ptd_delay, ptd_mul and ptd_div.
//
//   port     dir  handshake    carries
//   req_ch   in   valid/ready  query point and three corners
//   rsp_ch   out  valid/ready  squared distance, nearest point, feature, degenerate
//
// One item per cycle while no result is held at the output; the pipeline depth is set
// mostly by the one-bit-per-stage quotient pipeline.
// Synchronous reset clears only the valid bits.
// A held result stalls the whole pipeline; req_ch.ready drops only then.
module point_triangle_distance_unit #(
   parameter int COORD_WIDTH = ptd_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = ptd_pkg::FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ptd_req_if.sink   req_ch,
   ptd_rsp_if.source rsp_ch
);
   import ptd_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int EW  = W + 1;
   localparam int AW  = 2 * EW + 2;
   localparam int PW  = 2 * AW + 1;
   localparam int NW  = PW + 1;
   localparam int PF  = W + 4;
   localparam int SW  = PF + 2;
   localparam int MW  = SW + EW;
   localparam int XW  = MW + 2;
   localparam int CW  = XW - PF;
   localparam int DQ  = 2 * EW;
   localparam int DSW = DQ + 2;
   localparam int DW  = dist_width(W, F);
   localparam int SRW = $bits(src_type);
   localparam int GW  = 6 * W + 6 * EW;
   localparam int SBW = 3 + 2 * SRW + 2;
   localparam int LAT = PF + 18;

   localparam logic signed [CW-1:0]  PMAX   = CW'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [CW-1:0]  PMIN   = ~PMAX;
   localparam logic signed [XW-1:0]  HALF_P = XW'({1'b1, {(PF-1){1'b0}}});
   localparam logic signed [DSW-1:0] HALF_D = DSW'({1'b1, {(F-1){1'b0}}});
   localparam logic [PF:0]           ONE_Q  = {1'b1, {PF{1'b0}}};

   function automatic logic [PF:0] src_value(src_type src, logic [PF:0] qa, logic [PF:0] qb);
      logic [PF:0] r;
      case (src)
         SRC_ONE:          r = ONE_Q;
         SRC_QA:           r = qa;
         SRC_QB:           r = qb;
         SRC_ONE_MINUS_QA: r = ONE_Q - qa;
         default:          r = '0;
      endcase
      return r;
   endfunction

   logic            en;
   logic [LAT-1:0]  vld_ff;

   assign en           = !vld_ff[LAT-1] || rsp_ch.ready;
   assign req_ch.ready = en;
   assign rsp_ch.valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_ch.valid};
      end
   end

   // stage 0: capture
   logic signed [W-1:0] in_q_ff  [3];
   logic signed [W-1:0] in_v0_ff [3];
   logic signed [W-1:0] in_v1_ff [3];
   logic signed [W-1:0] in_v2_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         in_q_ff[0]  <= req_ch.query_x;
         in_q_ff[1]  <= req_ch.query_y;
         in_q_ff[2]  <= req_ch.query_z;
         in_v0_ff[0] <= req_ch.corner0_x;
         in_v0_ff[1] <= req_ch.corner0_y;
         in_v0_ff[2] <= req_ch.corner0_z;
         in_v1_ff[0] <= req_ch.corner1_x;
         in_v1_ff[1] <= req_ch.corner1_y;
         in_v1_ff[2] <= req_ch.corner1_z;
         in_v2_ff[0] <= req_ch.corner2_x;
         in_v2_ff[1] <= req_ch.corner2_y;
         in_v2_ff[2] <= req_ch.corner2_z;
      end
   end

   // stage 1: edges and offset
   logic signed [W-1:0]  q1_ff  [3];
   logic signed [W-1:0]  v01_ff [3];
   logic signed [EW-1:0] e0_ff  [3];
   logic signed [EW-1:0] e1_ff  [3];
   logic signed [EW-1:0] d_ff   [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            q1_ff[k]  <= in_q_ff[k];
            v01_ff[k] <= in_v0_ff[k];
            e0_ff[k]  <= EW'(in_v1_ff[k]) - EW'(in_v0_ff[k]);
            e1_ff[k]  <= EW'(in_v2_ff[k]) - EW'(in_v0_ff[k]);
            d_ff[k]   <= EW'(in_v0_ff[k]) - EW'(in_q_ff[k]);
         end
      end
   end

   // stages 2-3: dot product terms
   logic signed [DQ-1:0] p00 [3];
   logic signed [DQ-1:0] p01 [3];
   logic signed [DQ-1:0] p11 [3];
   logic signed [DQ-1:0] pd0 [3];
   logic signed [DQ-1:0] pd1 [3];

   for (genvar k = 0; k < 3; k++) begin : g_dot
      ptd_mul #(.AW(EW), .BW(EW)) u_m00 (
         .clock(clock), .en(en), .a(e0_ff[k]), .b(e0_ff[k]), .p(p00[k]));
      ptd_mul #(.AW(EW), .BW(EW)) u_m01 (
         .clock(clock), .en(en), .a(e0_ff[k]), .b(e1_ff[k]), .p(p01[k]));
      ptd_mul #(.AW(EW), .BW(EW)) u_m11 (
         .clock(clock), .en(en), .a(e1_ff[k]), .b(e1_ff[k]), .p(p11[k]));
      ptd_mul #(.AW(EW), .BW(EW)) u_md0 (
         .clock(clock), .en(en), .a(d_ff[k]), .b(e0_ff[k]), .p(pd0[k]));
      ptd_mul #(.AW(EW), .BW(EW)) u_md1 (
         .clock(clock), .en(en), .a(d_ff[k]), .b(e1_ff[k]), .p(pd1[k]));
   end

   // stage 4: dot products
   logic signed [AW-1:0] a00_ff, a01_ff, a11_ff, b0_ff, b1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a00_ff <= AW'(p00[0]) + AW'(p00[1]) + AW'(p00[2]);
         a01_ff <= AW'(p01[0]) + AW'(p01[1]) + AW'(p01[2]);
         a11_ff <= AW'(p11[0]) + AW'(p11[1]) + AW'(p11[2]);
         b0_ff  <= AW'(pd0[0]) + AW'(pd0[1]) + AW'(pd0[2]);
         b1_ff  <= AW'(pd1[0]) + AW'(pd1[1]) + AW'(pd1[2]);
      end
   end

   // stages 5-6: cross products
   logic signed [2*AW-1:0] m_a00a11, m_a01a01, m_a01b1, m_a11b0, m_a01b0, m_a00b1;

   ptd_mul #(.AW(AW), .BW(AW)) u_mx0 (
      .clock(clock), .en(en), .a(a00_ff), .b(a11_ff), .p(m_a00a11));
   ptd_mul #(.AW(AW), .BW(AW)) u_mx1 (
      .clock(clock), .en(en), .a(a01_ff), .b(a01_ff), .p(m_a01a01));
   ptd_mul #(.AW(AW), .BW(AW)) u_mx2 (
      .clock(clock), .en(en), .a(a01_ff), .b(b1_ff), .p(m_a01b1));
   ptd_mul #(.AW(AW), .BW(AW)) u_mx3 (
      .clock(clock), .en(en), .a(a11_ff), .b(b0_ff), .p(m_a11b0));
   ptd_mul #(.AW(AW), .BW(AW)) u_mx4 (
      .clock(clock), .en(en), .a(a01_ff), .b(b0_ff), .p(m_a01b0));
   ptd_mul #(.AW(AW), .BW(AW)) u_mx5 (
      .clock(clock), .en(en), .a(a00_ff), .b(b1_ff), .p(m_a00b1));

   logic [5*AW-1:0]      a_dly;
   logic signed [AW-1:0] a00_7, a01_7, a11_7, b0_7, b1_7;

   ptd_delay #(.WD(5 * AW), .DEPTH(2)) u_dly_a (
      .clock(clock), .en(en), .din({a00_ff, a01_ff, a11_ff, b0_ff, b1_ff}), .dout(a_dly));
   assign {a00_7, a01_7, a11_7, b0_7, b1_7} = a_dly;

   // stage 7: det, s, t
   logic signed [PW-1:0] det_diff;
   logic signed [PW-1:0] det_ff, s_ff, t_ff;
   logic signed [AW-1:0] a00_8i, a01_8i, a11_8i, b0_8i, b1_8i;

   assign det_diff = PW'(m_a00a11) - PW'(m_a01a01);

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff <= det_diff[PW-1] ? -det_diff : det_diff;
         s_ff   <= PW'(m_a01b1) - PW'(m_a11b0);
         t_ff   <= PW'(m_a01b0) - PW'(m_a00b1);
         a00_8i <= a00_7;
         a01_8i <= a01_7;
         a11_8i <= a11_7;
         b0_8i  <= b0_7;
         b1_8i  <= b1_7;
      end
   end

   // stage 8: region flags and edge numerators
   logic                   inr_ff, sn_ff, tn_ff, b0n_ff, b1n_ff, ae0_ff, ae1_ff, c2_ff, c6_ff;
   logic signed [AW+1:0]   n2_ff, n6_ff, dnm_ff;
   logic signed [AW:0]     nb0_ff, nb1_ff;
   logic signed [AW-1:0]   a00_8, a11_8;
   logic signed [PW-1:0]   s_8, t_8, det_8;
   logic signed [AW:0]     nb0_in, nb1_in;
   logic signed [AW+1:0]   n2_in, n6_in;

   assign nb0_in = -(AW+1)'(b0_8i);
   assign nb1_in = -(AW+1)'(b1_8i);
   assign n2_in  = ((AW+2)'(a11_8i) + (AW+2)'(b1_8i)) - ((AW+2)'(a01_8i) + (AW+2)'(b0_8i));
   assign n6_in  = ((AW+2)'(a00_8i) + (AW+2)'(b0_8i)) - ((AW+2)'(a01_8i) + (AW+2)'(b1_8i));

   always_ff @(posedge clock) begin
      if (en) begin
         inr_ff <= ((PW+1)'(s_ff) + (PW+1)'(t_ff)) <= (PW+1)'(det_ff);
         sn_ff  <= s_ff[PW-1];
         tn_ff  <= t_ff[PW-1];
         b0n_ff <= b0_8i[AW-1];
         b1n_ff <= b1_8i[AW-1];
         ae0_ff <= nb0_in >= (AW+1)'(a00_8i);
         ae1_ff <= nb1_in >= (AW+1)'(a11_8i);
         c2_ff  <= n2_in > 0;
         c6_ff  <= n6_in > 0;
         n2_ff  <= n2_in;
         n6_ff  <= n6_in;
         dnm_ff <= (AW+2)'(a00_8i) - ((AW+2)'(a01_8i) <<< 1) + (AW+2)'(a11_8i);
         nb0_ff <= nb0_in;
         nb1_ff <= nb1_in;
         a00_8  <= a00_8i;
         a11_8  <= a11_8i;
         s_8    <= s_ff;
         t_8    <= t_ff;
         det_8  <= det_ff;
      end
   end

   // stage 9: region decision
   logic [2:0]           feat_in;
   src_type              ssrc_in, tsrc_in;
   logic signed [NW-1:0] numa_in, dena_in, numb_in, denb_in;
   logic                 usea_in, useb_in, ge2, ge6;
   logic [2:0]           feat_ff;
   src_type              ssrc_ff, tsrc_ff;
   logic signed [NW-1:0] numa_ff, dena_ff, numb_ff, denb_ff;
   logic                 usea_ff, useb_ff;

   assign ge2 = n2_ff >= dnm_ff;
   assign ge6 = n6_ff >= dnm_ff;

   always_comb begin
      feat_in = FEAT_INTERIOR;
      ssrc_in = SRC_ZERO;
      tsrc_in = SRC_ZERO;
      numa_in = '0;
      dena_in = '0;
      numb_in = '0;
      denb_in = '0;
      usea_in = 1'b0;
      useb_in = 1'b0;
      if (inr_ff) begin
         if (sn_ff && !(tn_ff && b0n_ff)) begin
            if (!b1n_ff) begin
               feat_in = FEAT_VERTEX0;
            end else if (ae1_ff) begin
               feat_in = FEAT_VERTEX2;
               tsrc_in = SRC_ONE;
            end else begin
               feat_in = FEAT_EDGE20;
               tsrc_in = SRC_QA;
               numa_in = NW'(nb1_ff);
               dena_in = NW'(a11_8);
               usea_in = 1'b1;
            end
         end else if (sn_ff || tn_ff) begin
            if (!b0n_ff) begin
               feat_in = FEAT_VERTEX0;
            end else if (ae0_ff) begin
               feat_in = FEAT_VERTEX1;
               ssrc_in = SRC_ONE;
            end else begin
               feat_in = FEAT_EDGE01;
               ssrc_in = SRC_QA;
               numa_in = NW'(nb0_ff);
               dena_in = NW'(a00_8);
               usea_in = 1'b1;
            end
         end else begin
            ssrc_in = SRC_QA;
            tsrc_in = SRC_QB;
            numa_in = NW'(s_8);
            dena_in = NW'(det_8);
            numb_in = NW'(t_8);
            denb_in = NW'(det_8);
            usea_in = 1'b1;
            useb_in = 1'b1;
         end
      end else begin
         if (sn_ff) begin
            if (c2_ff) begin
               if (ge2) begin
                  feat_in = FEAT_VERTEX1;
                  ssrc_in = SRC_ONE;
               end else begin
                  feat_in = FEAT_EDGE12;
                  ssrc_in = SRC_QA;
                  tsrc_in = SRC_ONE_MINUS_QA;
                  numa_in = NW'(n2_ff);
                  dena_in = NW'(dnm_ff);
                  usea_in = 1'b1;
               end
            end else if (ae1_ff) begin
               feat_in = FEAT_VERTEX2;
               tsrc_in = SRC_ONE;
            end else if (!b1n_ff) begin
               feat_in = FEAT_VERTEX0;
            end else begin
               feat_in = FEAT_EDGE20;
               tsrc_in = SRC_QA;
               numa_in = NW'(nb1_ff);
               dena_in = NW'(a11_8);
               usea_in = 1'b1;
            end
         end else if (tn_ff) begin
            if (c6_ff) begin
               if (ge6) begin
                  feat_in = FEAT_VERTEX2;
                  tsrc_in = SRC_ONE;
               end else begin
                  feat_in = FEAT_EDGE12;
                  tsrc_in = SRC_QA;
                  ssrc_in = SRC_ONE_MINUS_QA;
                  numa_in = NW'(n6_ff);
                  dena_in = NW'(dnm_ff);
                  usea_in = 1'b1;
               end
            end else if (ae0_ff) begin
               feat_in = FEAT_VERTEX1;
               ssrc_in = SRC_ONE;
            end else if (!b0n_ff) begin
               feat_in = FEAT_VERTEX0;
            end else begin
               feat_in = FEAT_EDGE01;
               ssrc_in = SRC_QA;
               numa_in = NW'(nb0_ff);
               dena_in = NW'(a00_8);
               usea_in = 1'b1;
            end
         end else begin
            if (!c2_ff) begin
               feat_in = FEAT_VERTEX2;
               tsrc_in = SRC_ONE;
            end else if (ge2) begin
               feat_in = FEAT_VERTEX1;
               ssrc_in = SRC_ONE;
            end else begin
               feat_in = FEAT_EDGE12;
               ssrc_in = SRC_QA;
               tsrc_in = SRC_ONE_MINUS_QA;
               numa_in = NW'(n2_ff);
               dena_in = NW'(dnm_ff);
               usea_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         feat_ff <= feat_in;
         ssrc_ff <= ssrc_in;
         tsrc_ff <= tsrc_in;
         numa_ff <= numa_in;
         dena_ff <= dena_in;
         numb_ff <= numb_in;
         denb_ff <= denb_in;
         usea_ff <= usea_in;
         useb_ff <= useb_in;
      end
   end

   // quotient pipelines
   logic [PF:0] qa, qb;
   logic        dega, degb;

   ptd_div #(.NW(NW), .QB(PF)) u_div_a (
      .clock(clock), .en(en), .num(numa_ff), .den(dena_ff), .quo(qa), .deg(dega));
   ptd_div #(.NW(NW), .QB(PF)) u_div_b (
      .clock(clock), .en(en), .num(numb_ff), .den(denb_ff), .quo(qb), .deg(degb));

   logic [SBW-1:0] sb_dly;
   logic [2:0]     feat_d;
   logic [SRW-1:0] ssrc_d, tsrc_d;
   logic           usea_d, useb_d;

   ptd_delay #(.WD(SBW), .DEPTH(PF + 1)) u_dly_sb (
      .clock(clock), .en(en),
      .din({feat_ff, ssrc_ff, tsrc_ff, usea_ff, useb_ff}), .dout(sb_dly));
   assign {feat_d, ssrc_d, tsrc_d, usea_d, useb_d} = sb_dly;

   logic [GW-1:0]        geo_dly;
   logic signed [W-1:0]  g_q  [3];
   logic signed [W-1:0]  g_v0 [3];
   logic signed [EW-1:0] g_e0 [3];
   logic signed [EW-1:0] g_e1 [3];

   ptd_delay #(.WD(GW), .DEPTH(PF + 10)) u_dly_geo (
      .clock(clock), .en(en),
      .din({q1_ff[0], q1_ff[1], q1_ff[2], v01_ff[0], v01_ff[1], v01_ff[2],
            e0_ff[0], e0_ff[1], e0_ff[2], e1_ff[0], e1_ff[1], e1_ff[2]}),
      .dout(geo_dly));
   assign {g_q[0], g_q[1], g_q[2], g_v0[0], g_v0[1], g_v0[2],
           g_e0[0], g_e0[1], g_e0[2], g_e1[0], g_e1[1], g_e1[2]} = geo_dly;

   // parameters of the nearest point
   logic [PF:0] sv_ff, tv_ff;
   logic [2:0]  feat_p_ff;
   logic        deg_p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sv_ff     <= src_value(src_type'(ssrc_d), qa, qb);
         tv_ff     <= src_value(src_type'(tsrc_d), qa, qb);
         feat_p_ff <= feat_d;
         deg_p_ff  <= (usea_d && dega) || (useb_d && degb);
      end
   end

   logic signed [MW-1:0] se [3];
   logic signed [MW-1:0] te [3];

   for (genvar k = 0; k < 3; k++) begin : g_pt
      ptd_mul #(.AW(SW), .BW(EW)) u_ms (
         .clock(clock), .en(en), .a($signed({1'b0, sv_ff})), .b(g_e0[k]), .p(se[k]));
      ptd_mul #(.AW(SW), .BW(EW)) u_mt (
         .clock(clock), .en(en), .a($signed({1'b0, tv_ff})), .b(g_e1[k]), .p(te[k]));
   end

   logic [6*W-1:0]      vq_dly;
   logic signed [W-1:0] h_q  [3];
   logic signed [W-1:0] h_v0 [3];

   ptd_delay #(.WD(6 * W), .DEPTH(2)) u_dly_vq (
      .clock(clock), .en(en),
      .din({g_q[0], g_q[1], g_q[2], g_v0[0], g_v0[1], g_v0[2]}), .dout(vq_dly));
   assign {h_q[0], h_q[1], h_q[2], h_v0[0], h_v0[1], h_v0[2]} = vq_dly;

   // nearest point, rounded and clamped
   logic signed [W-1:0]  near_ff [3];
   logic signed [EW-1:0] diff_ff [3];

   for (genvar k = 0; k < 3; k++) begin : g_near
      logic signed [XW-1:0] psum;
      logic signed [CW-1:0] prnd;
      logic signed [W-1:0]  pcl;

      assign psum = (XW'(h_v0[k]) <<< PF) + XW'(se[k]) + XW'(te[k]) + HALF_P;
      assign prnd = psum[XW-1:PF];
      assign pcl  = (prnd > PMAX) ? PMAX[W-1:0] : (prnd < PMIN) ? PMIN[W-1:0] : prnd[W-1:0];

      always_ff @(posedge clock) begin
         if (en) begin
            near_ff[k] <= pcl;
            diff_ff[k] <= EW'(pcl) - EW'(h_q[k]);
         end
      end
   end

   logic signed [DQ-1:0] sq [3];

   for (genvar k = 0; k < 3; k++) begin : g_sq
      ptd_mul #(.AW(EW), .BW(EW)) u_msq (
         .clock(clock), .en(en), .a(diff_ff[k]), .b(diff_ff[k]), .p(sq[k]));
   end

   logic [3*W-1:0]      near_dly;
   logic signed [W-1:0] n_d [3];
   logic [3:0]          fd_dly;

   ptd_delay #(.WD(3 * W), .DEPTH(2)) u_dly_near (
      .clock(clock), .en(en), .din({near_ff[0], near_ff[1], near_ff[2]}), .dout(near_dly));
   assign {n_d[0], n_d[1], n_d[2]} = near_dly;

   ptd_delay #(.WD(4), .DEPTH(5)) u_dly_fd (
      .clock(clock), .en(en), .din({feat_p_ff, deg_p_ff}), .dout(fd_dly));

   // output stage: distance rounding and saturation
   logic signed [DSW-1:0] dsum;
   logic [DSW-F-1:0]      dshr;
   logic [DW-1:0]         dist_ff;
   logic signed [W-1:0]   out_near_ff [3];
   logic [2:0]            out_feat_ff;
   logic                  out_deg_ff;

   assign dsum = DSW'(sq[0]) + DSW'(sq[1]) + DSW'(sq[2]) + HALF_D;
   assign dshr = dsum[DSW-1:F];

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff     <= (|dshr[DSW-F-1:DW]) ? '1 : dshr[DW-1:0];
         out_near_ff <= n_d;
         out_feat_ff <= fd_dly[3:1];
         out_deg_ff  <= fd_dly[0];
      end
   end

   assign rsp_ch.dist_squared = dist_ff;
   assign rsp_ch.nearest_x    = out_near_ff[0];
   assign rsp_ch.nearest_y    = out_near_ff[1];
   assign rsp_ch.nearest_z    = out_near_ff[2];
   assign rsp_ch.feature      = out_feat_ff;
   assign rsp_ch.degenerate   = out_deg_ff;

`ifndef NO_ASSERTIONS
   a_deg_feature: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.degenerate |->
         rsp_ch.feature == FEAT_EDGE01 || rsp_ch.feature == FEAT_EDGE12 ||
         rsp_ch.feature == FEAT_EDGE20 || rsp_ch.feature == FEAT_INTERIOR)
      else $error("degenerate flag on a vertex feature");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |-> !req_ch.ready)
      else $error("input taken while output held");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result valid right after reset");

   a_feature_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.feature <= FEAT_INTERIOR)
      else $error("feature code out of range");
`endif
endmodule
